// File: hw/rtl/kdsl_pkg.sv
// ----------------------------------------------------------------------------
// kdsl_pkg: shared types and constants of the key debouncer
// Word layouts, mode and event codes, register indexes and per-key limits.
// ----------------------------------------------------------------------------
package kdsl_pkg;

  localparam int unsigned KEYS     = 4;
  localparam int unsigned RAW_BITS = 4;

  localparam logic [7:0]  RUN_MAX  = 8'hFF;
  localparam logic [31:0] HELD_CAP = 32'hFFFF_FF00;

  localparam logic [9:0]  SCAN_PERIOD_RST = 10'd10;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd1000;
  localparam logic [7:0]  DEBOUNCE_RST    = 8'd3;

  typedef enum logic [1:0] {
    MODE_SCAN    = 2'd0,
    MODE_READ    = 2'd1,
    MODE_CLR_ONE = 2'd2,
    MODE_CLR_ALL = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    REG_SCAN_PERIOD = 2'd0,
    REG_LONG_PRESS  = 2'd1,
    REG_DEBOUNCE    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] raw_levels;
    logic [1:0] key_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0] press_event;
    logic [3:0] pressed_mask;
  } out_word_t;

  typedef struct packed {
    logic [9:0]  scan_period_ms;
    logic [15:0] long_press_ms;
    logic [7:0]  debounce_count;
  } cfg_t;

  typedef struct packed {
    logic scan;
    logic level;
    logic clear;
  } key_ctrl_t;

endpackage

// File: hw/rtl/kdsl_key.sv
// ----------------------------------------------------------------------------
// kdsl_key: debounce and press timing of one key
// Holds the run counter, debounced level, held time and pending event.
// ----------------------------------------------------------------------------
module kdsl_key
  import kdsl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  key_ctrl_t  ctrl_i,
  output logic [1:0] pending_o,
  output logic       pressed_d_o
);

  logic        last_q, last_d;
  logic [7:0]  run_q, run_d;
  logic        pressed_q, pressed_d;
  logic        long_done_q, long_done_d;
  logic [31:0] held_q, held_d;
  logic [1:0]  pending_q, pending_d;

  logic [7:0]  run_next;
  logic [31:0] held_grow;
  logic [31:0] long_ext;
  logic        now_pressed;

  assign long_ext    = {16'd0, cfg_i.long_press_ms};
  assign now_pressed = ~ctrl_i.level;
  assign held_grow   = (held_q < HELD_CAP) ? held_q + {22'd0, cfg_i.scan_period_ms} : held_q;

  always_comb begin
    if (ctrl_i.level == last_q) begin
      run_next = (run_q == RUN_MAX) ? run_q : run_q + 8'd1;
    end else begin
      run_next = 8'd1;
    end
  end

  always_comb begin
    last_d      = last_q;
    run_d       = run_q;
    pressed_d   = pressed_q;
    long_done_d = long_done_q;
    held_d      = held_q;
    pending_d   = pending_q;
    if (ctrl_i.scan) begin
      last_d = ctrl_i.level;
      run_d  = run_next;
      if (run_next >= cfg_i.debounce_count) begin
        if (now_pressed != pressed_q) begin
          if (!now_pressed && !long_done_q && (held_q < long_ext)) begin
            pending_d = EV_SHORT;
          end
          held_d      = '0;
          long_done_d = 1'b0;
          pressed_d   = now_pressed;
        end else if (now_pressed) begin
          held_d = held_grow;
          if (!long_done_q && (held_grow >= long_ext)) begin
            pending_d   = EV_LONG;
            long_done_d = 1'b1;
          end
        end
      end
    end else if (ctrl_i.clear) begin
      pending_d = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b1;
      run_q       <= '0;
      pressed_q   <= 1'b0;
      long_done_q <= 1'b0;
      held_q      <= '0;
      pending_q   <= EV_NONE;
    end else begin
      last_q      <= last_d;
      run_q       <= run_d;
      pressed_q   <= pressed_d;
      long_done_q <= long_done_d;
      held_q      <= held_d;
      pending_q   <= pending_d;
    end
  end

  assign pending_o   = pending_q;
  assign pressed_d_o = pressed_d;

  a_long_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_done_q |-> pressed_q) else $error("long press flag set on released key");

  a_held_needs_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != 32'd0) |-> pressed_q) else $error("held time nonzero on released key");

  a_pending_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q == EV_NONE) || (pending_q == EV_SHORT) || (pending_q == EV_LONG))
    else $error("pending event holds a reserved code");

endmodule

// File: hw/rtl/key_debounce_short_long_press.sv
// ----------------------------------------------------------------------------
// key_debounce_short_long_press: four-key debouncer with short/long events
// The result word is registered behind the input register; one word per cycle while the output is not stalled.
// The input register feeds per-key update logic that writes the result register.
// A stalled result word holds both registers and stalls the input.
// Reset clears all key state, loads register defaults, empties both stages.
// ----------------------------------------------------------------------------
module key_debounce_short_long_press
  import kdsl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t      cfg_q;
  in_word_t  in_q;
  logic      in_vld_q;
  out_word_t out_q, out_d;
  logic      out_vld_q;
  logic      advance;

  key_ctrl_t  ctrl   [KEYS];
  logic [1:0] pending[KEYS];
  logic [KEYS-1:0] pressed_nxt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scan_period_ms <= SCAN_PERIOD_RST;
      cfg_q.long_press_ms  <= LONG_PRESS_RST;
      cfg_q.debounce_count <= DEBOUNCE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SCAN_PERIOD: cfg_q.scan_period_ms <= cfg_data_i[9:0];
        REG_LONG_PRESS:  cfg_q.long_press_ms  <= cfg_data_i;
        REG_DEBOUNCE:    cfg_q.debounce_count <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_word_i;
    end
  end

  for (genvar k = 0; k < KEYS; k++) begin : g_key
    always_comb begin
      ctrl[k].scan  = advance && (in_q.mode == MODE_SCAN);
      ctrl[k].level = (k < RAW_BITS) ? in_q.raw_levels[k % RAW_BITS] : 1'b1;
      ctrl[k].clear = advance && ((in_q.mode == MODE_CLR_ALL) ||
                      (((in_q.mode == MODE_READ) || (in_q.mode == MODE_CLR_ONE)) &&
                       ({30'd0, in_q.key_index} == k)));
    end

    kdsl_key u_key (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg_q),
      .ctrl_i      (ctrl[k]),
      .pending_o   (pending[k]),
      .pressed_d_o (pressed_nxt[k])
    );
  end

  always_comb begin
    out_d = '0;
    for (int k = 0; k < KEYS; k++) begin
      if ((in_q.mode == MODE_READ) && ({30'd0, in_q.key_index} == k)) begin
        out_d.press_event = pending[k];
      end
      if (k < RAW_BITS) begin
        out_d.pressed_mask[k % RAW_BITS] = pressed_nxt[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

// File: test/key_debounce_short_long_press_tb.sv
// ----------------------------------------------------------------------------
// key_debounce_short_long_press_tb: self-checking bench for the key debouncer
// Scan, read and clear words go in with random gaps against a random output
// stall. A cycle-free predictor of the four keys computes each result word,
// and a checker compares every accepted result with the oldest one queued.
// Directed tests cover defaults, events, threshold changes and backpressure;
// random phases sweep register settings from one extreme to the other.
// ----------------------------------------------------------------------------
module key_debounce_short_long_press_tb;
  import kdsl_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         IDLE_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_word_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  key_debounce_short_long_press dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic        level_seen [KEYS];
  logic [7:0]  run_len    [KEYS];
  logic        is_pressed [KEYS];
  logic        long_fired [KEYS];
  logic [31:0] held_ms    [KEYS];
  event_e      latched_ev [KEYS];
  logic [9:0]  scan_ms;
  logic [15:0] long_ms;
  logic [7:0]  settle_cnt;

  out_word_t   reports_due[$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  logic [3:0]  key_aim = 4'hF;
  bit          steady_in = 1'b0;
  bit          steady_out = 1'b0;
  int          hold_req = 0;
  int          hold_left = 0;
  int          stall_left = 0;

  function automatic void reset_keys();
    for (int k = 0; k < KEYS; k++) begin
      level_seen[k] = 1'b1;
      run_len[k]    = '0;
      is_pressed[k] = 1'b0;
      long_fired[k] = 1'b0;
      held_ms[k]    = '0;
      latched_ev[k] = EV_NONE;
    end
    scan_ms    = SCAN_PERIOD_RST;
    long_ms    = LONG_PRESS_RST;
    settle_cnt = DEBOUNCE_RST;
  endfunction

  function automatic out_word_t debounce_step(in_word_t w);
    out_word_t r;
    logic      lvl;
    r.press_event  = EV_NONE;
    r.pressed_mask = '0;
    case (mode_e'(w.mode))
      MODE_SCAN: begin
        for (int k = 0; k < KEYS; k++) begin
          lvl = w.raw_levels[k];
          if (lvl == level_seen[k]) begin
            if (run_len[k] != RUN_MAX) run_len[k]++;
          end else begin
            level_seen[k] = lvl;
            run_len[k] = 8'd1;
          end
          if (run_len[k] >= settle_cnt) begin
            if (!lvl != is_pressed[k]) begin
              if (lvl && !long_fired[k] && held_ms[k] < 32'(long_ms))
                latched_ev[k] = EV_SHORT;
              held_ms[k]    = '0;
              long_fired[k] = 1'b0;
              is_pressed[k] = !lvl;
            end else if (!lvl) begin
              if (held_ms[k] < HELD_CAP) held_ms[k] += 32'(scan_ms);
              if (!long_fired[k] && held_ms[k] >= 32'(long_ms)) begin
                latched_ev[k] = EV_LONG;
                long_fired[k] = 1'b1;
              end
            end
          end
        end
      end
      MODE_READ: begin
        r.press_event = latched_ev[w.key_index];
        latched_ev[w.key_index] = EV_NONE;
      end
      MODE_CLR_ONE: latched_ev[w.key_index] = EV_NONE;
      default: begin
        for (int k = 0; k < KEYS; k++) latched_ev[k] = EV_NONE;
      end
    endcase
    for (int k = 0; k < KEYS && k < RAW_BITS; k++) r.pressed_mask[k] = is_pressed[k];
    return r;
  endfunction

  function automatic int pick_gap();
    int r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_word_t random_word(int hold_mean, int noise_pct);
    in_word_t w;
    int       r;
    r = $urandom_range(0, 99);
    w.raw_levels = 4'($urandom);
    w.key_index  = 2'($urandom);
    if (r < 75) begin
      w.mode = MODE_SCAN;
      for (int k = 0; k < KEYS; k++) begin
        if ($urandom_range(0, hold_mean) == 0) key_aim[k] = ~key_aim[k];
        w.raw_levels[k] = key_aim[k] ^ ($urandom_range(0, 99) < noise_pct);
      end
    end else if (r < 87) begin
      w.mode = MODE_READ;
    end else if (r < 95) begin
      w.mode = MODE_CLR_ONE;
    end else begin
      w.mode = MODE_CLR_ALL;
    end
    return w;
  endfunction

  task automatic send_word(mode_e mode, logic [3:0] raw, logic [1:0] idx);
    in_word_t w;
    int       gap;
    w.mode = mode;
    w.raw_levels = raw;
    w.key_index = idx;
    gap = steady_in ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i  = w;
    do @(posedge clk_i); while (in_stall_o);
    reports_due.push_back(debounce_step(w));
  endtask

  task automatic send_random(int count, int hold_mean, int noise_pct);
    in_word_t w;
    repeat (count) begin
      w = random_word(hold_mean, noise_pct);
      send_word(mode_e'(w.mode), w.raw_levels, w.key_index);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SCAN_PERIOD: scan_ms = data[9:0];
      REG_LONG_PRESS:  long_ms = data;
      REG_DEBOUNCE:    settle_cnt = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else if (steady_out) begin
      out_stall_i = 1'b0;
    end else if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reports_due.size() == 0) begin
        $error("unexpected result word: %p", out_word_o);
        mismatches++;
      end else begin
        exp_w = reports_due.pop_front();
        if (out_word_o.press_event !== exp_w.press_event) begin
          $error("press_event: expected %0d, got %0d",
                 exp_w.press_event, out_word_o.press_event);
          mismatches++;
        end
        if (out_word_o.pressed_mask !== exp_w.pressed_mask) begin
          $error("pressed_mask: expected %b, got %b",
                 exp_w.pressed_mask, out_word_o.pressed_mask);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("key_debounce_short_long_press: mismatch");
        $finish;
      end
    end
  end

  task automatic test_defaults();
    send_word(MODE_SCAN, 4'hF, 2'd0);
    repeat (3) send_word(MODE_SCAN, 4'h0, 2'd0);
    repeat (3) send_word(MODE_SCAN, 4'hF, 2'd3);
    send_word(MODE_READ, 4'h0, 2'd0);
    send_word(MODE_CLR_ONE, 4'hF, 2'd1);
    send_word(MODE_READ, 4'h0, 2'd1);
    send_word(MODE_READ, 4'hF, 2'd2);
    send_word(MODE_CLR_ALL, 4'h0, 2'd2);
    send_word(MODE_READ, 4'hF, 2'd3);
    drain_results();
  endtask

  task automatic test_long_press();
    write_reg(REG_SCAN_PERIOD, 16'd1000);
    write_reg(REG_LONG_PRESS, 16'd1000);
    write_reg(REG_DEBOUNCE, 16'd1);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_word(MODE_SCAN, 4'b0111, 2'd0);
    send_word(MODE_SCAN, 4'b0111, 2'd0);
    send_word(MODE_READ, 4'hF, 2'd3);
    send_word(MODE_SCAN, 4'hF, 2'd0);
    send_word(MODE_READ, 4'h0, 2'd3);
    drain_results();
  endtask

  task automatic test_threshold_drop();
    write_reg(REG_LONG_PRESS, 16'hFFFF);
    repeat (3) send_word(MODE_SCAN, 4'b1100, 2'd0);
    drain_results();
    write_reg(REG_LONG_PRESS, 16'd1500);
    send_word(MODE_SCAN, 4'b1110, 2'd0);
    send_word(MODE_READ, 4'h0, 2'd0);
    send_word(MODE_READ, 4'h0, 2'd1);
    drain_results();
  endtask

  task automatic test_backpressure();
    steady_in = 1'b1;
    hold_req = 200;
    send_random(60, 30, 5);
    steady_in = 1'b0;
    drain_results();
  endtask

  task automatic run_phase(logic [15:0] scan_d, logic [15:0] long_d, logic [15:0] settle_d,
                           int hold_mean, int noise_pct, int count);
    write_reg(REG_DEBOUNCE, settle_d);
    if ($urandom_range(0, 1)) write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_LONG_PRESS, long_d);
    write_reg(REG_SCAN_PERIOD, scan_d);
    send_random(count, hold_mean, noise_pct);
    drain_results();
  endtask

  task automatic test_random_phases();
    run_phase(16'd0, 16'd1, 16'd1, 20, 10, 200);
    run_phase(16'd0, 16'd0, 16'd0, 20, 10, 200);
    run_phase(16'd1000, 16'hFFFF, 16'd255, 400, 0, 500);
    steady_in = 1'b1;
    steady_out = 1'b1;
    run_phase(16'd10, 16'd1000, 16'd3, 120, 5, 300);
    steady_in = 1'b0;
    steady_out = 1'b0;
    repeat (4) begin
      run_phase({6'($urandom), 10'($urandom)}, 16'($urandom_range(0, 3000)),
                {8'($urandom), 8'($urandom_range(0, 6))},
                $urandom_range(10, 150), $urandom_range(0, 8), 200);
    end
  endtask

  initial begin
    reset_keys();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_long_press();
    test_threshold_drop();
    test_backpressure();
    test_random_phases();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("key_debounce_short_long_press: match");
    end else begin
      $display("key_debounce_short_long_press: mismatch");
    end
    $finish;
  end

endmodule
